// ===== design/lpr_pkg.sv =====
// shared types and constants for the lru page replacement block
package lpr_pkg;

    // default build sizes
    localparam int DEF_MAX_FRAMES = 16;
    localparam int DEF_PAGE_BITS  = 16;

    // fixed field widths of the stream words
    localparam int PAGE_W        = 16;
    localparam int FRAME_IDX_W   = 4;
    localparam int TOTAL_W       = 16;
    localparam int FRAME_COUNT_W = 5;
    localparam int IN_TDATA_W    = 16;
    localparam int IN_TUSER_W    = 1;
    localparam int OUT_TDATA_W   = 56;
    localparam int OUT_TUSER_W   = 2;

    // reset value of the frame count register
    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 5'd3;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_COMMIT
    } state_t;

    // what a reference does to the frames
    typedef enum logic [1:0] {
        KIND_HIT,
        KIND_FILL,
        KIND_EVICT
    } kind_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic decide;
        logic commit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

// ===== design/lpr_ctrl.sv =====
// controller state machine sequencing lookup and commit of each page reference
module lpr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lpr_pkg::status_t status,
    output lpr_pkg::cmd_t    cmd
);

    lpr_pkg::state_t state_reg;
    lpr_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            lpr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = lpr_pkg::ST_DECIDE;
                end
            end
            lpr_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = lpr_pkg::ST_COMMIT;
            end
            lpr_pkg::ST_COMMIT:
            begin
                // commit only once the output register can take the word
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    s_tready   = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = lpr_pkg::ST_DECIDE;
                    end
                    else
                    begin
                        state_next = lpr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lpr_pkg::ST_IDLE;
            end
        endcase
    end

    // a decided reference is always committed next or held for the output
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lpr_pkg::ST_DECIDE |=> state_reg == lpr_pkg::ST_COMMIT)
        else $error("decide not followed by commit");

    // never capture a new word while the previous one is still undecided
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !(state_reg == lpr_pkg::ST_DECIDE))
        else $error("capture during decide");

endmodule

// ===== design/lpr_datapath.sv =====
// frame registers, tag compare, victim select, rank update, totals and output register
module lpr_datapath
#(
    parameter int MAX_FRAMES = lpr_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lpr_pkg::DEF_PAGE_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lpr_pkg::cmd_t                     cmd,
    output lpr_pkg::status_t                  status,
    input  logic [lpr_pkg::PAGE_W-1:0]        in_page,
    input  logic                              in_restart,
    input  logic                              cfg_valid,
    input  logic [lpr_pkg::FRAME_COUNT_W-1:0] cfg_data,
    input  logic                              m_tready,
    output logic                              out_valid,
    output logic                              out_hit,
    output logic [lpr_pkg::FRAME_IDX_W-1:0]   out_frame_index,
    output logic                              out_evicted_valid,
    output logic [lpr_pkg::PAGE_W-1:0]        out_evicted_page,
    output logic [lpr_pkg::TOTAL_W-1:0]       out_hit_total,
    output logic [lpr_pkg::TOTAL_W-1:0]       out_reference_total
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FW = $clog2(MAX_FRAMES + 1);
    localparam logic [lpr_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

    // captured reference
    logic [PAGE_BITS-1:0]              page_reg;
    logic                              restart_reg;

    // configuration and frame state
    logic [lpr_pkg::FRAME_COUNT_W-1:0] frame_count_reg;
    logic [PAGE_BITS-1:0]              resident_reg [MAX_FRAMES];
    logic [IW-1:0]                     rank_reg     [MAX_FRAMES];
    logic [IW-1:0]                     rank_next    [MAX_FRAMES];
    logic [FW-1:0]                     filled_reg;
    logic [FW-1:0]                     filled_next;
    logic [lpr_pkg::TOTAL_W-1:0]       hits_reg;
    logic [lpr_pkg::TOTAL_W-1:0]       hits_next;
    logic [lpr_pkg::TOTAL_W-1:0]       refs_reg;
    logic [lpr_pkg::TOTAL_W-1:0]       refs_next;

    // decision registers
    lpr_pkg::kind_t                    kind_reg;
    lpr_pkg::kind_t                    kind_next;
    logic [IW-1:0]                     f_reg;
    logic [IW-1:0]                     f_next;

    // output register
    logic                              out_valid_reg;

    // lookup signals
    logic [FW-1:0]                     n_eff;
    logic [FW-1:0]                     filled_eff;
    logic [FW-1:0]                     active;
    logic [IW-1:0]                     rank_eff [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]             match;
    logic [MAX_FRAMES-1:0]             match_first;
    logic [MAX_FRAMES-1:0]             victim;
    logic [IW-1:0]                     hit_idx;
    logic [IW-1:0]                     victim_idx;
    logic [IW-1:0]                     f_rank;

    assign status.out_busy = out_valid_reg && !m_tready;
    assign out_valid       = out_valid_reg;

    // effective frame count, zero acts as one, clamped to capacity
    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            n_eff = FW'(1);
        end
        else if (32'(frame_count_reg) > 32'(MAX_FRAMES))
        begin
            n_eff = FW'(MAX_FRAMES);
        end
        else
        begin
            n_eff = FW'(frame_count_reg);
        end
    end

    // state as seen after an optional restart
    assign filled_eff = restart_reg ? '0 : filled_reg;
    assign active     = (filled_eff < n_eff) ? filled_eff : n_eff;

    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            rank_eff[i] = restart_reg ? '0 : rank_reg[i];
        end
    end

    // parallel tag compare over the active frames
    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            match[i] = (32'(i) < 32'(active)) && (resident_reg[i] == page_reg);
        end
    end

    // lowest matching frame wins
    assign match_first = match & (~match + MAX_FRAMES'(1));

    // victim: largest rank among frames in use, lowest index on a tie
    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            victim[i] = (32'(i) < 32'(n_eff));
            for (int j = 0; j < MAX_FRAMES; j++)
            begin
                if ((32'(j) < 32'(n_eff)) && (j != i))
                begin
                    if (j < i)
                    begin
                        victim[i] = victim[i] && (rank_eff[j] < rank_eff[i]);
                    end
                    else
                    begin
                        victim[i] = victim[i] && (rank_eff[j] <= rank_eff[i]);
                    end
                end
            end
        end
    end

    // one-hot to index
    always_comb
    begin
        hit_idx    = '0;
        victim_idx = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (match_first[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
            if (victim[i])
            begin
                victim_idx = victim_idx | IW'(i);
            end
        end
    end

    // decision: hit, fill next empty frame, or evict
    always_comb
    begin
        if (|match)
        begin
            kind_next = lpr_pkg::KIND_HIT;
            f_next    = hit_idx;
        end
        else if (filled_eff < n_eff)
        begin
            kind_next = lpr_pkg::KIND_FILL;
            f_next    = IW'(filled_eff);
        end
        else
        begin
            kind_next = lpr_pkg::KIND_EVICT;
            f_next    = victim_idx;
        end
    end

    // rank update, fill count and totals for the commit cycle
    assign f_rank = rank_eff[f_reg];

    always_comb
    begin
        filled_next = filled_eff;
        if (kind_reg == lpr_pkg::KIND_FILL)
        begin
            filled_next = filled_eff + FW'(1);
        end
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            rank_next[i] = rank_eff[i];
            if (IW'(i) == f_reg)
            begin
                rank_next[i] = '0;
            end
            else if ((32'(i) < 32'(filled_next))
                     && ((kind_reg == lpr_pkg::KIND_FILL) || (rank_eff[i] < f_rank)))
            begin
                rank_next[i] = rank_eff[i] + IW'(1);
            end
        end
        hits_next = restart_reg ? '0 : hits_reg;
        if ((kind_reg == lpr_pkg::KIND_HIT) && (hits_next != TOTAL_MAX))
        begin
            hits_next = hits_next + 1'b1;
        end
        refs_next = restart_reg ? '0 : refs_reg;
        if (refs_next != TOTAL_MAX)
        begin
            refs_next = refs_next + 1'b1;
        end
    end

    // captured reference and decision, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg    <= PAGE_BITS'(in_page);
            restart_reg <= in_restart;
        end
        if (cmd.decide)
        begin
            kind_reg <= kind_next;
            f_reg    <= f_next;
        end
    end

    // resident pages, written on fill or evict
    always_ff @(posedge clk)
    begin
        if (cmd.commit && (kind_reg != lpr_pkg::KIND_HIT))
        begin
            resident_reg[f_reg] <= page_reg;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit             <= (kind_reg == lpr_pkg::KIND_HIT);
            out_frame_index     <= lpr_pkg::FRAME_IDX_W'(f_reg);
            out_evicted_valid   <= (kind_reg == lpr_pkg::KIND_EVICT);
            out_evicted_page    <= (kind_reg == lpr_pkg::KIND_EVICT)
                                   ? lpr_pkg::PAGE_W'(resident_reg[f_reg]) : '0;
            out_hit_total       <= hits_next;
            out_reference_total <= refs_next;
        end
    end

    // control state: config, ranks, fill count, totals, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= lpr_pkg::FRAME_COUNT_RESET;
            filled_reg      <= '0;
            hits_reg        <= '0;
            refs_reg        <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                frame_count_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                filled_reg    <= filled_next;
                hits_reg      <= hits_next;
                refs_reg      <= refs_next;
                out_valid_reg <= 1'b1;
                for (int i = 0; i < MAX_FRAMES; i++)
                begin
                    rank_reg[i] <= rank_next[i];
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // committed frame becomes most recent
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rank_reg[f_reg] == '0)
        else $error("committed frame rank not zero");

    // fill count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(filled_reg) <= 32'(MAX_FRAMES))
        else $error("fill count above capacity");

    // no commit overwrites a word still waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !m_tready))
        else $error("commit over stalled output word");

    // a hit never reports an eviction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit && out_evicted_valid))
        else $error("hit with eviction");

endmodule

// ===== design/lru_page_replacement.sv =====
// top level of the fully associative lru page replacement block
//
//  channel  direction  handshake          contents
//  s_*      in         s_tvalid/s_tready  tdata: page; tuser: restart
//  m_*      out        m_tvalid/m_tready  tdata: frame_index, evicted_page, totals;
//                                         tuser: hit, evicted_valid
//  cfg_*    in         cfg_valid/cfg_ready frame_count
//
//  each reference goes through a decide state, which compares the page against all frame
//  registers and picks the victim, then a commit state that updates ranks, pages and totals.
//  the next word is taken in the commit cycle, while the last reference commits.
//  a stalled output word holds the commit; s_tready stays low until it drains.
//  reset clears ranks, fill count and totals and sets frame_count to 3; no clearing pass.
module lru_page_replacement
#(
    parameter int MAX_FRAMES = lpr_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_BITS  = lpr_pkg::DEF_PAGE_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lpr_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] page
    input  logic [lpr_pkg::IN_TUSER_W-1:0]    s_tuser,   // [0] restart
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [3:0] frame_index, [19:4] evicted_page, [35:20] hit_total,
    // [51:36] reference_total, [55:52] zero
    output logic [lpr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [lpr_pkg::OUT_TUSER_W-1:0]   m_tuser,   // [0] hit, [1] evicted_valid
    // frame count register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpr_pkg::FRAME_COUNT_W-1:0] cfg_data
);

    lpr_pkg::cmd_t                   cmd;
    lpr_pkg::status_t                status;
    logic                            out_hit;
    logic [lpr_pkg::FRAME_IDX_W-1:0] out_frame_index;
    logic                            out_evicted_valid;
    logic [lpr_pkg::PAGE_W-1:0]      out_evicted_page;
    logic [lpr_pkg::TOTAL_W-1:0]     out_hit_total;
    logic [lpr_pkg::TOTAL_W-1:0]     out_reference_total;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencing
    lpr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // frames and result
    lpr_datapath
    #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    )
    u_datapath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .in_page             (s_tdata),
        .in_restart          (s_tuser[0]),
        .cfg_valid           (cfg_valid && cfg_ready),
        .cfg_data            (cfg_data),
        .m_tready            (m_tready),
        .out_valid           (m_tvalid),
        .out_hit             (out_hit),
        .out_frame_index     (out_frame_index),
        .out_evicted_valid   (out_evicted_valid),
        .out_evicted_page    (out_evicted_page),
        .out_hit_total       (out_hit_total),
        .out_reference_total (out_reference_total)
    );

    // pack result word
    assign m_tdata = {4'b0000, out_reference_total, out_hit_total,
                      out_evicted_page, out_frame_index};
    assign m_tuser = {out_evicted_valid, out_hit};

endmodule

// ===== tb/sv/lru_page_replacement_tb.sv =====
// self-checking testbench for the lru page replacement block
`timescale 1ns / 1ps

module lru_page_replacement_tb;

    import lpr_pkg::*;

    localparam int FRAMES = DEF_MAX_FRAMES;
    localparam logic [TOTAL_W-1:0] TOTAL_TOP = '1;

    // one result word split into its fields
    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_W-1:0]      evicted_page;
        logic [TOTAL_W-1:0]     hit_total;
        logic [TOTAL_W-1:0]     reference_total;
    } lru_result_t;

    // one row of the directed table: optional frame count write, reference, typed result
    typedef struct packed {
        logic                     do_cfg;
        logic [FRAME_COUNT_W-1:0] cfg_value;
        logic [PAGE_W-1:0]        page;
        logic                     restart;
        logic                     typed;
        lru_result_t              want;
    } ref_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata;   // [15:0] page
    logic [IN_TUSER_W-1:0]    s_tuser;   // [0] restart
    logic                     m_tvalid;
    logic                     m_tready;
    // [3:0] frame_index, [19:4] evicted_page, [35:20] hit_total,
    // [51:36] reference_total, [55:52] zero
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic [OUT_TUSER_W-1:0]   m_tuser;   // [0] hit, [1] evicted_valid
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [FRAME_COUNT_W-1:0] cfg_data;

    // mirror of the block state
    logic [PAGE_W-1:0]        frame_page [FRAMES];
    logic [FRAME_IDX_W-1:0]   frame_rank [FRAMES];
    logic [4:0]               frames_filled;
    logic [TOTAL_W-1:0]       hit_count;
    logic [TOTAL_W-1:0]       ref_count;
    logic [FRAME_COUNT_W-1:0] frame_limit;

    lru_result_t pending_results [$];
    ref_row_t    ref_table [21];
    int          mismatches;
    bit          idle_on;
    int          stall_left;

    lru_page_replacement DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // random gap length: mostly short, a few long
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_TOP) ? v : v + 1'b1;
    endfunction

    // make frame f the most recent, aging every filled frame younger than limit
    function automatic void promote_frame(input int f, input int limit);
        for (int i = 0; i < int'(frames_filled) && i < FRAMES; i++)
        begin
            if (i != f && int'(frame_rank[i]) < limit)
                frame_rank[i] = frame_rank[i] + 1'b1;
        end
        frame_rank[f] = '0;
    endfunction

    // lru lookup, fill or eviction for one reference
    task automatic predict_reference(input logic [PAGE_W-1:0] page, input logic restart,
                                     output lru_result_t r);
        int  n;
        int  active;
        int  f;
        int  best;
        bit  found;
        n = (frame_limit == 0) ? 1 : ((int'(frame_limit) > FRAMES) ? FRAMES : int'(frame_limit));
        if (restart)
        begin
            foreach (frame_rank[i])
                frame_rank[i] = '0;
            frames_filled = '0;
            hit_count     = '0;
            ref_count     = '0;
        end
        active = (int'(frames_filled) < n) ? int'(frames_filled) : n;
        found  = 1'b0;
        f      = 0;
        for (int i = 0; i < active; i++)
        begin
            if (!found && frame_page[i] == page)
            begin
                found = 1'b1;
                f     = i;
            end
        end
        r = '0;
        if (found)
        begin
            promote_frame(f, int'(frame_rank[f]));
            hit_count = sat_inc(hit_count);
        end
        else if (int'(frames_filled) < n)
        begin
            f = int'(frames_filled);
            frame_page[f] = page;
            frames_filled = frames_filled + 1'b1;
            promote_frame(f, FRAMES + 1);
        end
        else
        begin
            // oldest active frame, lowest index on a tie
            best = 0;
            for (int i = 1; i < n; i++)
            begin
                if (frame_rank[i] > frame_rank[best])
                    best = i;
            end
            f = best;
            r.evicted_valid = 1'b1;
            r.evicted_page  = frame_page[f];
            frame_page[f]   = page;
            promote_frame(f, int'(frame_rank[f]));
        end
        ref_count         = sat_inc(ref_count);
        r.hit             = found;
        r.frame_index     = f[FRAME_IDX_W-1:0];
        r.hit_total       = hit_count;
        r.reference_total = ref_count;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result side: ready with random stalls while idle_on is set, always ready otherwise
    always @(negedge clk)
    begin
        if (!idle_on)
            m_tready = 1'b1;
        else if (stall_left > 0)
        begin
            m_tready = 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            m_tready   = 1'b0;
            stall_left = gap_len() - 1;
        end
        else
            m_tready = 1'b1;
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        lru_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %0h",
                         $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit", want.hit, m_tuser[0]);
                check_field("evicted_valid", want.evicted_valid, m_tuser[1]);
                check_field("frame_index", want.frame_index, m_tdata[3:0]);
                check_field("evicted_page", want.evicted_page, m_tdata[19:4]);
                check_field("hit_total", want.hit_total, m_tdata[35:20]);
                check_field("reference_total", want.reference_total, m_tdata[51:36]);
            end
        end
    end

    // send one reference word; called at a falling edge, returns at a falling edge
    task automatic send_reference(input logic [PAGE_W-1:0] page, input logic restart,
                                  input logic typed, input lru_result_t typed_want);
        lru_result_t r;
        int          gap;
        if (idle_on && $urandom_range(0, 99) >= 55)
        begin
            gap = gap_len();
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid   = 1'b1;
        s_tdata    = page;
        s_tuser[0] = restart;
        do
            @(posedge clk);
        while (!s_tready);
        predict_reference(page, restart, r);
        pending_results.insert(pending_results.size(), typed ? typed_want : r);
        @(negedge clk);
    endtask

    // hold the sender until every result has come
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_frame_count(input logic [FRAME_COUNT_W-1:0] value);
        drain_results();
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        frame_limit = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // main sequence
    initial
    begin
        logic [PAGE_W-1:0]        pool [24];
        int                       pool_size;
        int                       drain_at;
        int                       roll;
        logic [PAGE_W-1:0]        page;
        logic [FRAME_COUNT_W-1:0] fc_plan [7];

        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        mismatches = 0;
        idle_on    = 1'b1;
        stall_left = 0;

        foreach (frame_page[i])
        begin
            frame_page[i] = '0;
            frame_rank[i] = '0;
        end
        frames_filled = '0;
        hit_count     = '0;
        ref_count     = '0;
        frame_limit   = FRAME_COUNT_RESET;

        // cfg, value, page, restart, typed, {hit, frame, ev_valid, ev_page, hits, refs}
        ref_table = '{
            '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd0, 16'd1}},
            '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 16'd0, 16'd2}},
            '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd1, 16'd3}},
            '{1'b0, 5'd0,  16'h8001, 1'b0, 1'b1, '{1'b0, 4'd2, 1'b0, 16'h0000, 16'd1, 16'd4}},
            '{1'b0, 5'd0,  16'h1234, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b1, 16'hFFFF, 16'd1, 16'd5}},
            '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h0000, 16'd1, 16'd6}},
            '{1'b0, 5'd0,  16'h1234, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd0, 16'd1}},
            // zero frame count acts as one frame
            '{1'b1, 5'd0,  16'h1234, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 16'd1, 16'd2}},
            '{1'b0, 5'd0,  16'h5555, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h1234, 16'd1, 16'd3}},
            '{1'b1, 5'd16, 16'hAAAA, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 16'd0, 16'd1}},
            '{1'b0, 5'd0,  16'hBBBB, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 16'd0, 16'd2}},
            '{1'b0, 5'd0,  16'hCCCC, 1'b0, 1'b1, '{1'b0, 4'd2, 1'b0, 16'h0000, 16'd0, 16'd3}},
            // count lowered below the filled frames, raised past capacity, then lowered and raised again
            '{1'b1, 5'd2,  16'hCCCC, 1'b0, 1'b0, '0},
            '{1'b0, 5'd0,  16'hBBBB, 1'b0, 1'b0, '0},
            '{1'b1, 5'd17, 16'hCCCC, 1'b0, 1'b0, '0},
            '{1'b0, 5'd0,  16'hDDDD, 1'b0, 1'b0, '0},
            '{1'b1, 5'd1,  16'hDDDD, 1'b0, 1'b0, '0},
            '{1'b1, 5'd31, 16'h0F0F, 1'b1, 1'b0, '0},
            '{1'b0, 5'd0,  16'hF0F0, 1'b0, 1'b0, '0},
            '{1'b1, 5'd3,  16'h7FFF, 1'b0, 1'b0, '0},
            '{1'b0, 5'd0,  16'h7FFF, 1'b0, 1'b0, '0}
        };
        fc_plan = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd2, 5'd15};

        // reset
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        foreach (ref_table[k])
        begin
            if (ref_table[k].do_cfg)
                write_frame_count(ref_table[k].cfg_value);
            send_reference(ref_table[k].page, ref_table[k].restart,
                           ref_table[k].typed, ref_table[k].want);
        end

        // random phases: working set of random pages, some noise and restarts
        for (int phase = 0; phase < 8; phase++)
        begin
            write_frame_count(phase < 7 ? fc_plan[phase] : FRAME_COUNT_W'($urandom_range(0, 31)));
            idle_on   = (phase != 3);
            pool_size = $urandom_range(1, 24);
            for (int i = 0; i < pool_size; i++)
                pool[i] = PAGE_W'($urandom);
            drain_at = $urandom_range(20, 180);
            for (int i = 0; i < 200; i++)
            begin
                if (i == drain_at)
                    drain_results();
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    page = pool[$urandom_range(0, pool_size - 1)];
                else if (roll < 95)
                    page = PAGE_W'($urandom);
                else
                    page = $urandom_range(0, 1) ? '1 : '0;
                send_reference(page, $urandom_range(0, 99) < 2, 1'b0, '0);
            end
        end

        // back-to-back hit run over a small working set, then random evictions
        write_frame_count(5'd4);
        idle_on = 1'b0;
        send_reference(16'h0010, 1'b1, 1'b0, '0);
        for (int i = 0; i < 20; i++)
            send_reference(PAGE_W'(16'h0010 * (1 + $urandom_range(0, 3))), 1'b0, 1'b0, '0);
        idle_on = 1'b1;
        for (int i = 0; i < 10; i++)
            send_reference(PAGE_W'($urandom), 1'b0, 1'b0, '0);

        // wait out the remaining results
        drain_results();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
